>>> src/tcdma_pkg.sv
// ----------------------------------------------------------------------------
// tcdma_pkg
// Shared constants and types for the two-channel decimating moving average.
// ----------------------------------------------------------------------------
package tcdma_pkg;

  localparam int SAMPLE_COUNT = 16;
  localparam int SAMPLE_W     = 16;
  localparam int IDX_W        = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int CNT_W        = IDX_W;
  localparam int SUM_W        = SAMPLE_W + IDX_W;

  localparam int OQ_DEPTH     = 4;
  localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W     = OQ_PTR_W + 1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic take;
    logic last;
    logic commit;
  } lane_ctrl_t;

  typedef struct packed {
    sample_t voltage;
    sample_t current;
  } result_t;

endpackage

>>> src/tcdma_lane.sv
// ----------------------------------------------------------------------------
// tcdma_lane
// One channel: running block sum, block average, history ring and window sum.
// ----------------------------------------------------------------------------
module tcdma_lane
  import tcdma_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  sample_t    sample,
  output sample_t    smoothed
);

  logic [SUM_W-1:0] block_sum;
  logic [SUM_W-1:0] block_sum_next;
  sample_t          block_avg;
  sample_t          history [SAMPLE_COUNT];
  logic [SUM_W-1:0] window_sum;
  logic [IDX_W-1:0] oldest;
  logic             primed;

  assign block_sum_next = block_sum + SUM_W'(sample);
  assign smoothed       = SAMPLE_W'(window_sum / SUM_W'(SAMPLE_COUNT));

  // accumulate the block and form its average
  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum <= '0;
    end else if (ctrl.take) begin
      if (ctrl.last) begin
        block_sum <= '0;
      end else begin
        block_sum <= block_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take && ctrl.last) begin
      block_avg <= SAMPLE_W'(block_sum_next / SUM_W'(SAMPLE_COUNT));
    end
  end

  // push the average into the history and advance the window
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      oldest     <= '0;
      primed     <= 1'b0;
    end else if (ctrl.commit) begin
      if (!primed) begin
        window_sum <= SUM_W'(block_avg) * SUM_W'(SAMPLE_COUNT);
        oldest     <= '0;
        primed     <= 1'b1;
      end else begin
        window_sum <= window_sum - SUM_W'(history[oldest]) + SUM_W'(block_avg);
        if (oldest == IDX_W'(SAMPLE_COUNT - 1)) begin
          oldest <= '0;
        end else begin
          oldest <= oldest + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
        history[i] <= '0;
      end
    end else if (ctrl.commit) begin
      if (!primed) begin
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
          history[i] <= block_avg;
        end
      end else begin
        history[oldest] <= block_avg;
      end
    end
  end

endmodule

>>> src/tcdma_outq.sv
// ----------------------------------------------------------------------------
// tcdma_outq
// Merge stage: joins both lane results into one request and queues it.
// ----------------------------------------------------------------------------
module tcdma_outq
  import tcdma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sample_t             lane_voltage,
  input  sample_t             lane_current,
  input  logic                pop,
  output logic                not_empty,
  output result_t             head,
  output logic [OQ_CNT_W-1:0] count
);

  result_t             entries [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic                do_pop;

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{voltage: lane_voltage, current: lane_current};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + OQ_CNT_W'(1);
        2'b01:   count <= count - OQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/two_channel_decimate_moving_average.sv
// ----------------------------------------------------------------------------
// two_channel_decimate_moving_average
// Boxcar decimator with moving average over the last block averages, two
// channels in parallel lanes, results queued in a small output buffer.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall   voltage_sample, current_sample
//   out      source     out_valid/out_stall smoothed_voltage, smoothed_current
//
// One sample pair is taken every cycle while in_valid is high and in_stall
// is low. A block's result moves through block average, window update, queue.
// The queue holds four results; the last pair of a block stalls only while
// four results are queued or in flight. Mid-block pairs never stall.
// Reset clears sums, counters, history and the queue; no warm-up pass.
// ----------------------------------------------------------------------------
module two_channel_decimate_moving_average
  import tcdma_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t voltage_sample,
  input  sample_t current_sample,
  output logic    out_valid,
  input  logic    out_stall,
  output sample_t smoothed_voltage,
  output sample_t smoothed_current
);

  logic [CNT_W-1:0]    block_count;
  logic                last;
  logic                take;
  logic                avg_valid;
  logic                res_valid;
  logic [OQ_CNT_W-1:0] q_count;
  logic [OQ_CNT_W-1:0] in_flight;
  lane_ctrl_t          ctrl;
  sample_t             lane_voltage;
  sample_t             lane_current;
  result_t             head;

  assign last      = (block_count == CNT_W'(SAMPLE_COUNT - 1));
  assign in_flight = q_count + OQ_CNT_W'(avg_valid) + OQ_CNT_W'(res_valid);
  assign in_stall  = last && (in_flight >= OQ_CNT_W'(OQ_DEPTH));
  assign take      = in_valid && !in_stall;
  assign ctrl      = '{take: take, last: last, commit: avg_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      avg_valid   <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      avg_valid <= take && last;
      res_valid <= avg_valid;
      if (take) begin
        if (last) begin
          block_count <= '0;
        end else begin
          block_count <= block_count + CNT_W'(1);
        end
      end
    end
  end

  tcdma_lane u_lane_voltage (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .sample   (voltage_sample),
    .smoothed (lane_voltage)
  );

  tcdma_lane u_lane_current (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .sample   (current_sample),
    .smoothed (lane_current)
  );

  tcdma_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (res_valid),
    .lane_voltage (lane_voltage),
    .lane_current (lane_current),
    .pop          (!out_stall),
    .not_empty    (out_valid),
    .head         (head),
    .count        (q_count)
  );

  assign smoothed_voltage = head.voltage;
  assign smoothed_current = head.current;

endmodule
